// File: hw/rtl/i2cmt_pkg.sv
`default_nettype none

package i2cmt_pkg;

    // Command codes carried in the input tuser
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_TICK  = 2'd0;
    localparam mode_t MODE_WRITE = 2'd1;
    localparam mode_t MODE_READ  = 2'd2;
    localparam mode_t MODE_LOAD  = 2'd3;

    // Bus sequencer phases
    typedef logic [3:0] phase_t;
    localparam phase_t PH_IDLE     = 4'd0;
    localparam phase_t PH_START1   = 4'd1;
    localparam phase_t PH_START2   = 4'd2;
    localparam phase_t PH_W_LOW    = 4'd3;
    localparam phase_t PH_W_HIGH   = 4'd4;
    localparam phase_t PH_ACK_LOW  = 4'd5;
    localparam phase_t PH_ACK_HIGH = 4'd6;
    localparam phase_t PH_WAIT     = 4'd7;
    localparam phase_t PH_R_LOW    = 4'd8;
    localparam phase_t PH_R_HIGH   = 4'd9;
    localparam phase_t PH_RA_LOW   = 4'd10;
    localparam phase_t PH_RA_HIGH  = 4'd11;
    localparam phase_t PH_STOP_LOW = 4'd12;
    localparam phase_t PH_STOP_HI  = 4'd13;
    localparam phase_t PH_STOP_END = 4'd14;

    // Input tdata layout
    localparam int IN_ADDR_LSB  = 0;
    localparam int IN_COUNT_LSB = 7;
    localparam int IN_WBYTE_LSB = 15;
    localparam int IN_SDA_BIT   = 23;
    localparam int IN_TDATA_W   = 24;

    // Output tdata layout
    localparam int OUT_SCL_BIT   = 0;
    localparam int OUT_SDA_BIT   = 1;
    localparam int OUT_BUSY_BIT  = 2;
    localparam int OUT_NEED_BIT  = 3;
    localparam int OUT_RBYTE_LSB = 4;
    localparam int OUT_OK_BIT    = 12;
    localparam int OUT_TDATA_W   = 16;

endpackage

`default_nettype wire

// File: hw/rtl/i2c_master_transfer_core.sv
// The result of a transfer accepted on s_axis is on m_axis in the next cycle.
// Throughput: one item per cycle unless m_axis stalls; each item's phase
// update is one pass of logic between the state and result registers.
// Input is taken whenever the result register is empty or being drained.
// Reset (rst_n low, asynchronous): sequencer idle, SCL and SDA released,
// result register empty. The hold byte register is not reset.
`default_nettype none

module i2c_master_transfer_core #(
    parameter int MAX_BYTES = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: address[6:0], byte_count[14:7], write_byte[22:15], sda_level[23]
    input  wire logic [23:0] s_axis_tdata,
    // tuser: mode[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: scl_level[0], sda_release[1], busy_res[2], need_byte[3],
    //        read_byte[11:4], ok[12], zero fill [15:13]
    output logic [15:0]      m_axis_tdata,
    // tuser: byte_valid[0]
    output logic             m_axis_tuser,
    // tlast: done_res
    output logic             m_axis_tlast
);

    // Counts come in as 8 bits, so the remaining-byte counter never needs
    // more than the smaller of the limit and 255.
    localparam int LIM  = (MAX_BYTES < 255) ? MAX_BYTES : 255;
    localparam int BL_W = (LIM < 2) ? 1 : $clog2(LIM + 1);

    // Unpack the input transfer
    i2cmt_pkg::mode_t mode;
    logic [6:0]       in_addr;
    logic [7:0]       in_count;
    logic [7:0]       in_wbyte;
    logic             in_sda;

    assign mode     = s_axis_tuser;
    assign in_addr  = s_axis_tdata[i2cmt_pkg::IN_ADDR_LSB  +: 7];
    assign in_count = s_axis_tdata[i2cmt_pkg::IN_COUNT_LSB +: 8];
    assign in_wbyte = s_axis_tdata[i2cmt_pkg::IN_WBYTE_LSB +: 8];
    assign in_sda   = s_axis_tdata[i2cmt_pkg::IN_SDA_BIT];

    // Sequencer state
    i2cmt_pkg::phase_t phase_reg, phase_next;
    logic [2:0]        bit_index_reg, bit_index_next;
    logic [7:0]        shift_data_reg, shift_data_next;
    logic [BL_W-1:0]   bytes_left_reg, bytes_left_next;
    logic              read_dir_reg, read_dir_next;
    logic [7:0]        hold_byte_reg, hold_byte_next;
    logic              hold_full_reg, hold_full_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              nack_reg, nack_next;

    // Result register
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       out_data_reg, out_data_next;
    logic              out_bvalid_reg, out_bvalid_next;
    logic              out_done_reg, out_done_next;

    logic              accept;
    logic              bvalid;
    logic [7:0]        rbyte;
    logic              done;
    logic              okv;
    logic [7:0]        rd_shift;
    logic [BL_W-1:0]   count_clamped;
    logic [BL_W-1:0]   bytes_dec;

    // Take a new item whenever the result slot frees up this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Clamp the requested count to the configured limit
    always_comb
    begin
        if ({9'd0, in_count} > 17'(LIM))
            count_clamped = BL_W'(LIM);
        else
            count_clamped = BL_W'(in_count);
    end

    // Saturating decrement of the remaining-byte counter
    assign bytes_dec = (bytes_left_reg != '0) ? bytes_left_reg - BL_W'(1) : bytes_left_reg;

    // Read sample merged into the current shift value
    assign rd_shift = shift_data_reg | (8'(in_sda) << bit_index_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        shift_data_next = shift_data_reg;
        bytes_left_next = bytes_left_reg;
        read_dir_next   = read_dir_reg;
        hold_byte_next  = hold_byte_reg;
        hold_full_next  = hold_full_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        nack_next       = nack_reg;
        bvalid          = 1'b0;
        rbyte           = 8'd0;
        done            = 1'b0;
        okv             = 1'b0;

        case (mode)
            i2cmt_pkg::MODE_WRITE, i2cmt_pkg::MODE_READ:
            begin
                // Ignore a start unless idle
                if (phase_reg == i2cmt_pkg::PH_IDLE)
                begin
                    read_dir_next   = (mode == i2cmt_pkg::MODE_READ);
                    shift_data_next = {in_addr, (mode == i2cmt_pkg::MODE_READ)};
                    bytes_left_next = count_clamped;
                    bit_index_next  = 3'd7;
                    hold_full_next  = 1'b0;
                    nack_next       = 1'b0;
                    scl_next        = 1'b1;
                    sda_next        = 1'b1;
                    phase_next      = i2cmt_pkg::PH_START1;
                end
            end
            i2cmt_pkg::MODE_LOAD:
            begin
                if (phase_reg != i2cmt_pkg::PH_IDLE && !read_dir_reg)
                begin
                    if (phase_reg == i2cmt_pkg::PH_WAIT)
                    begin
                        // Byte arrives while waiting: start shifting it out
                        shift_data_next = in_wbyte;
                        bit_index_next  = 3'd7;
                        bytes_left_next = bytes_dec;
                        scl_next        = 1'b0;
                        sda_next        = in_wbyte[7];
                        phase_next      = i2cmt_pkg::PH_W_LOW;
                    end
                    else
                    begin
                        hold_byte_next = in_wbyte;
                        hold_full_next = 1'b1;
                    end
                end
            end
            default:
            begin
                // Tick: advance one half SCL period
                case (phase_reg)
                    i2cmt_pkg::PH_START1:
                    begin
                        sda_next   = 1'b0;
                        phase_next = i2cmt_pkg::PH_START2;
                    end
                    i2cmt_pkg::PH_START2:
                    begin
                        scl_next       = 1'b0;
                        bit_index_next = 3'd7;
                        sda_next       = shift_data_reg[7];
                        phase_next     = i2cmt_pkg::PH_W_LOW;
                    end
                    i2cmt_pkg::PH_W_LOW:
                    begin
                        scl_next   = 1'b1;
                        phase_next = i2cmt_pkg::PH_W_HIGH;
                    end
                    i2cmt_pkg::PH_W_HIGH:
                    begin
                        scl_next = 1'b0;
                        if (bit_index_reg != 3'd0)
                        begin
                            bit_index_next = bit_index_reg - 3'd1;
                            sda_next       = shift_data_reg[bit_index_reg - 3'd1];
                            phase_next     = i2cmt_pkg::PH_W_LOW;
                        end
                        else
                        begin
                            // Release SDA for the slave's acknowledge
                            sda_next   = 1'b1;
                            phase_next = i2cmt_pkg::PH_ACK_LOW;
                        end
                    end
                    i2cmt_pkg::PH_ACK_LOW:
                    begin
                        scl_next   = 1'b1;
                        phase_next = i2cmt_pkg::PH_ACK_HIGH;
                    end
                    i2cmt_pkg::PH_ACK_HIGH:
                    begin
                        scl_next = 1'b0;
                        if (in_sda)
                        begin
                            // NACK: abort with STOP
                            nack_next  = 1'b1;
                            sda_next   = 1'b0;
                            phase_next = i2cmt_pkg::PH_STOP_LOW;
                        end
                        else if (bytes_left_reg == '0)
                        begin
                            sda_next   = 1'b0;
                            phase_next = i2cmt_pkg::PH_STOP_LOW;
                        end
                        else if (read_dir_reg)
                        begin
                            sda_next        = 1'b1;
                            shift_data_next = 8'd0;
                            bit_index_next  = 3'd7;
                            phase_next      = i2cmt_pkg::PH_R_LOW;
                        end
                        else if (hold_full_reg)
                        begin
                            // Use the byte loaded ahead of time
                            hold_full_next  = 1'b0;
                            shift_data_next = hold_byte_reg;
                            bit_index_next  = 3'd7;
                            bytes_left_next = bytes_dec;
                            sda_next        = hold_byte_reg[7];
                            phase_next      = i2cmt_pkg::PH_W_LOW;
                        end
                        else
                        begin
                            // Hold SCL low until the next byte is loaded
                            sda_next   = 1'b1;
                            phase_next = i2cmt_pkg::PH_WAIT;
                        end
                    end
                    i2cmt_pkg::PH_R_LOW:
                    begin
                        scl_next   = 1'b1;
                        phase_next = i2cmt_pkg::PH_R_HIGH;
                    end
                    i2cmt_pkg::PH_R_HIGH:
                    begin
                        scl_next        = 1'b0;
                        shift_data_next = rd_shift;
                        if (bit_index_reg != 3'd0)
                        begin
                            bit_index_next = bit_index_reg - 3'd1;
                            phase_next     = i2cmt_pkg::PH_R_LOW;
                        end
                        else
                        begin
                            bvalid          = 1'b1;
                            rbyte           = rd_shift;
                            bytes_left_next = bytes_dec;
                            // ACK all but the last byte
                            sda_next        = (bytes_dec == '0);
                            phase_next      = i2cmt_pkg::PH_RA_LOW;
                        end
                    end
                    i2cmt_pkg::PH_RA_LOW:
                    begin
                        scl_next   = 1'b1;
                        phase_next = i2cmt_pkg::PH_RA_HIGH;
                    end
                    i2cmt_pkg::PH_RA_HIGH:
                    begin
                        scl_next = 1'b0;
                        if (bytes_left_reg != '0)
                        begin
                            sda_next        = 1'b1;
                            shift_data_next = 8'd0;
                            bit_index_next  = 3'd7;
                            phase_next      = i2cmt_pkg::PH_R_LOW;
                        end
                        else
                        begin
                            sda_next   = 1'b0;
                            phase_next = i2cmt_pkg::PH_STOP_LOW;
                        end
                    end
                    i2cmt_pkg::PH_STOP_LOW:
                    begin
                        scl_next   = 1'b1;
                        phase_next = i2cmt_pkg::PH_STOP_HI;
                    end
                    i2cmt_pkg::PH_STOP_HI:
                    begin
                        sda_next   = 1'b1;
                        phase_next = i2cmt_pkg::PH_STOP_END;
                    end
                    i2cmt_pkg::PH_STOP_END:
                    begin
                        done           = 1'b1;
                        okv            = !nack_reg;
                        hold_full_next = 1'b0;
                        phase_next     = i2cmt_pkg::PH_IDLE;
                    end
                    default:
                    begin
                        // Idle and waiting phases hold on a tick
                    end
                endcase
            end
        endcase
    end

    // Result register: load on accept, drop once taken downstream
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_bvalid_next = out_bvalid_reg;
        out_done_next   = out_done_reg;
        if (accept)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = '0;
            out_data_next[i2cmt_pkg::OUT_SCL_BIT]        = scl_next;
            out_data_next[i2cmt_pkg::OUT_SDA_BIT]        = sda_next;
            out_data_next[i2cmt_pkg::OUT_BUSY_BIT]       = (phase_next != i2cmt_pkg::PH_IDLE);
            out_data_next[i2cmt_pkg::OUT_NEED_BIT]       = (phase_next == i2cmt_pkg::PH_WAIT);
            out_data_next[i2cmt_pkg::OUT_RBYTE_LSB +: 8] = rbyte;
            out_data_next[i2cmt_pkg::OUT_OK_BIT]         = okv;
            out_bvalid_next = bvalid;
            out_done_next   = done;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= i2cmt_pkg::PH_IDLE;
            bit_index_reg  <= 3'd0;
            shift_data_reg <= 8'd0;
            bytes_left_reg <= '0;
            read_dir_reg   <= 1'b0;
            hold_full_reg  <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            nack_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                bit_index_reg  <= bit_index_next;
                shift_data_reg <= shift_data_next;
                bytes_left_reg <= bytes_left_next;
                read_dir_reg   <= read_dir_next;
                hold_full_reg  <= hold_full_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                nack_reg       <= nack_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            hold_byte_reg <= hold_byte_next;
        out_data_reg   <= out_data_next;
        out_bvalid_reg <= out_bvalid_next;
        out_done_reg   <= out_done_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_bvalid_reg;
    assign m_axis_tlast  = out_done_reg;

endmodule

`default_nettype wire

// File: hw/rtl/i2cmt_checker.sv
`default_nettype none

module i2cmt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);

    logic busy;
    logic need;
    logic scl;
    logic ok;

    assign busy = m_axis_tdata[i2cmt_pkg::OUT_BUSY_BIT];
    assign need = m_axis_tdata[i2cmt_pkg::OUT_NEED_BIT];
    assign scl  = m_axis_tdata[i2cmt_pkg::OUT_SCL_BIT];
    assign ok   = m_axis_tdata[i2cmt_pkg::OUT_OK_BIT];

    // A finished transfer leaves the engine idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> !busy)
        else $error("done reported while still busy");

    // Waiting for a write byte keeps SCL low inside a transfer
    a_need_scl: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && need) |-> (busy && !scl))
        else $error("need_byte without busy and SCL low");

    // Status ok only accompanies done
    a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ok) |-> m_axis_tlast)
        else $error("ok without done");

    // A read byte is delivered only mid transfer, otherwise the byte field is zero
    a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser ? busy
            : (m_axis_tdata[i2cmt_pkg::OUT_RBYTE_LSB +: 8] == 8'd0)))
        else $error("read byte outside a transfer or nonzero without byte_valid");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind i2c_master_transfer_core i2cmt_checker u_i2cmt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: test/i2c_transfer_checker.sv
module i2c_transfer_checker
    import i2cmt_pkg::*;
#(
    parameter int MAX_BYTES = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,
    input  wire logic        m_axis_tuser,
    input  wire logic        m_axis_tlast,
    output int               errors,
    output int               outstanding
);

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       need;
        logic       rvalid;
        logic [7:0] rbyte;
        logic       done;
        logic       ok;
    } bus_result_t;

    bus_result_t expected_bus_q[$];

    // Shadow copy of the sequencer
    phase_t     ph;
    logic [2:0] bit_idx;
    logic [7:0] shreg;
    logic [7:0] left;
    logic       rd;
    logic [7:0] hold;
    logic       hold_full;
    logic       scl_q;
    logic       sda_q;
    logic       nack;

    function automatic void clear_sequencer();
        ph        = PH_IDLE;
        bit_idx   = '0;
        shreg     = '0;
        left      = '0;
        rd        = 1'b0;
        hold      = '0;
        hold_full = 1'b0;
        scl_q     = 1'b1;
        sda_q     = 1'b1;
        nack      = 1'b0;
    endfunction

    function automatic void start_byte(logic [7:0] value);
        shreg   = value;
        bit_idx = 3'd7;
        if (left != 0)
            left = left - 8'd1;
        scl_q = 1'b0;
        sda_q = value[7];
        ph    = PH_W_LOW;
    endfunction

    function automatic void enter_stop();
        scl_q = 1'b0;
        sda_q = 1'b0;
        ph    = PH_STOP_LOW;
    endfunction

    // Advance the shadow sequencer by one transfer and return the bus state it leaves
    function automatic bus_result_t predict_bus_step(mode_t mode, logic [23:0] d);
        logic [6:0]  addr;
        logic [7:0]  cnt;
        logic [7:0]  wb;
        logic        sda_in;
        bus_result_t r;
        addr   = d[IN_ADDR_LSB +: 7];
        cnt    = d[IN_COUNT_LSB +: 8];
        wb     = d[IN_WBYTE_LSB +: 8];
        sda_in = d[IN_SDA_BIT];
        r      = '0;
        case (mode)
            MODE_WRITE, MODE_READ:
            begin
                if (ph == PH_IDLE)
                begin
                    rd        = (mode == MODE_READ);
                    shreg     = {addr, rd};
                    left      = (cnt > MAX_BYTES) ? 8'(MAX_BYTES) : cnt;
                    bit_idx   = 3'd7;
                    hold_full = 1'b0;
                    nack      = 1'b0;
                    scl_q     = 1'b1;
                    sda_q     = 1'b1;
                    ph        = PH_START1;
                end
            end
            MODE_LOAD:
            begin
                if (ph != PH_IDLE && !rd)
                begin
                    if (ph == PH_WAIT)
                        start_byte(wb);
                    else
                    begin
                        hold      = wb;
                        hold_full = 1'b1;
                    end
                end
            end
            default:
            begin
                case (ph)
                    PH_START1:
                    begin
                        sda_q = 1'b0;
                        ph    = PH_START2;
                    end
                    PH_START2:
                    begin
                        scl_q   = 1'b0;
                        bit_idx = 3'd7;
                        sda_q   = shreg[7];
                        ph      = PH_W_LOW;
                    end
                    PH_W_LOW:
                    begin
                        scl_q = 1'b1;
                        ph    = PH_W_HIGH;
                    end
                    PH_W_HIGH:
                    begin
                        scl_q = 1'b0;
                        if (bit_idx != 0)
                        begin
                            bit_idx = bit_idx - 3'd1;
                            sda_q   = shreg[bit_idx];
                            ph      = PH_W_LOW;
                        end
                        else
                        begin
                            sda_q = 1'b1;
                            ph    = PH_ACK_LOW;
                        end
                    end
                    PH_ACK_LOW:
                    begin
                        scl_q = 1'b1;
                        ph    = PH_ACK_HIGH;
                    end
                    PH_ACK_HIGH:
                    begin
                        scl_q = 1'b0;
                        if (sda_in)
                        begin
                            nack = 1'b1;
                            enter_stop();
                        end
                        else if (left == 0)
                            enter_stop();
                        else if (rd)
                        begin
                            sda_q   = 1'b1;
                            shreg   = '0;
                            bit_idx = 3'd7;
                            ph      = PH_R_LOW;
                        end
                        else if (hold_full)
                        begin
                            hold_full = 1'b0;
                            start_byte(hold);
                        end
                        else
                        begin
                            sda_q = 1'b1;
                            ph    = PH_WAIT;
                        end
                    end
                    PH_R_LOW:
                    begin
                        scl_q = 1'b1;
                        ph    = PH_R_HIGH;
                    end
                    PH_R_HIGH:
                    begin
                        scl_q          = 1'b0;
                        shreg[bit_idx] = shreg[bit_idx] | sda_in;
                        if (bit_idx != 0)
                        begin
                            bit_idx = bit_idx - 3'd1;
                            ph      = PH_R_LOW;
                        end
                        else
                        begin
                            r.rvalid = 1'b1;
                            r.rbyte  = shreg;
                            if (left != 0)
                                left = left - 8'd1;
                            // ACK all but the last byte
                            sda_q = (left == 0);
                            ph    = PH_RA_LOW;
                        end
                    end
                    PH_RA_LOW:
                    begin
                        scl_q = 1'b1;
                        ph    = PH_RA_HIGH;
                    end
                    PH_RA_HIGH:
                    begin
                        if (left != 0)
                        begin
                            scl_q   = 1'b0;
                            sda_q   = 1'b1;
                            shreg   = '0;
                            bit_idx = 3'd7;
                            ph      = PH_R_LOW;
                        end
                        else
                            enter_stop();
                    end
                    PH_STOP_LOW:
                    begin
                        scl_q = 1'b1;
                        ph    = PH_STOP_HI;
                    end
                    PH_STOP_HI:
                    begin
                        sda_q = 1'b1;
                        ph    = PH_STOP_END;
                    end
                    PH_STOP_END:
                    begin
                        r.done    = 1'b1;
                        r.ok      = !nack;
                        hold_full = 1'b0;
                        ph        = PH_IDLE;
                    end
                    default:
                    begin
                    end
                endcase
            end
        endcase
        r.scl  = scl_q;
        r.sda  = sda_q;
        r.busy = (ph != PH_IDLE);
        r.need = (ph == PH_WAIT);
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic check_field(string what, int got, int want);
        if (got != want)
            report(what, got, want);
    endtask

    initial
    begin
        errors      = 0;
        outstanding = 0;
        clear_sequencer();
    end

    // Retire the result first: it always belongs to an earlier input transfer
    always @(posedge clk or negedge rst_n)
    begin : monitor
        bus_result_t want;
        if (!rst_n)
        begin
            clear_sequencer();
            expected_bus_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bus_q.size() == 0)
                    report("unexpected result", m_axis_tdata, 0);
                else
                begin
                    want = expected_bus_q.pop_front();
                    check_field("scl_level", m_axis_tdata[OUT_SCL_BIT], want.scl);
                    check_field("sda_release", m_axis_tdata[OUT_SDA_BIT], want.sda);
                    check_field("busy", m_axis_tdata[OUT_BUSY_BIT], want.busy);
                    check_field("need_byte", m_axis_tdata[OUT_NEED_BIT], want.need);
                    check_field("read_byte", m_axis_tdata[OUT_RBYTE_LSB +: 8], want.rbyte);
                    check_field("ok", m_axis_tdata[OUT_OK_BIT], want.ok);
                    check_field("tdata fill", m_axis_tdata[OUT_TDATA_W-1:OUT_OK_BIT+1], 0);
                    check_field("byte_valid", m_axis_tuser, want.rvalid);
                    check_field("done", m_axis_tlast, want.done);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_bus_q.push_back(predict_bus_step(s_axis_tuser, s_axis_tdata));
        end
        outstanding = expected_bus_q.size();
    end

endmodule

// File: test/testbench.sv
module testbench;
    import i2cmt_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // address[6:0], byte_count[14:7], write_byte[22:15], sda[23]
    logic [1:0]  s_axis_tuser;    // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // scl, sda, busy, need, read_byte[11:4], ok[12], fill
    logic        m_axis_tuser;    // byte_valid
    logic        m_axis_tlast;    // done

    int mismatches;
    int outstanding;
    int items_sent = 0;

    // Set by the stimulus, consumed by the result sink for one long hold-off
    bit rx_hold_req = 1'b0;
    // No idling on either side once set
    bit calm = 1'b0;

    always #5 clk = ~clk;

    i2c_master_transfer_core #(
        .MAX_BYTES(255)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    i2c_transfer_checker #(
        .MAX_BYTES(255)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (mismatches),
        .outstanding   (outstanding)
    );

    // Offer one item and hold it until the transfer completes.
    // Entered and left at a rising edge; tvalid stays high between back-to-back items.
    task automatic send_item(mode_t mode, int unsigned addr, int unsigned cnt,
                             int unsigned wb, int unsigned sda);
        if (!calm && $urandom_range(0, 11) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {sda[0], wb[7:0], cnt[7:0], addr[6:0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drop a start command on a bus that is already busy; the block must ignore it
    task automatic send_stray_start();
        send_item($urandom_range(0, 1) ? MODE_WRITE : MODE_READ,
                  $urandom, $urandom, $urandom, $urandom);
    endtask

    // Write transfer of n bytes. Ticks are counted only when they advance the bus;
    // ack slot s (0 = address, k = data byte k-1) is sampled on tick 20 + 18*s.
    // nack_slot > n means every slot is acknowledged.
    task automatic run_write(int unsigned addr, int n, int nack_slot);
        int stop_slot;
        int last_tick;
        int lo;
        int slot;
        int unsigned sda;
        int load_at[];
        bit late[];
        bit twice[];
        stop_slot = (nack_slot < n) ? nack_slot : n;
        last_tick = 23 + 18 * stop_slot;
        load_at   = new[stop_slot];
        late      = new[stop_slot];
        twice     = new[stop_slot];
        // Byte k is due on tick 20 + 18*k; load it early into the hold register
        // somewhere after byte k-1 was taken, or late while the bus waits for it
        for (int k = 0; k < stop_slot; k++)
        begin
            late[k]    = ($urandom_range(0, 3) == 0);
            lo         = (k == 0) ? 0 : 2 + 18 * k;
            load_at[k] = late[k] ? 20 + 18 * k : $urandom_range(lo, 19 + 18 * k);
            twice[k]   = !late[k] && ($urandom_range(0, 7) == 0);
        end
        send_item(MODE_WRITE, addr, n, $urandom, $urandom);
        for (int e = 0; e <= last_tick; e++)
        begin
            if (e > 0)
            begin
                slot = (e - 20) / 18;
                if (e >= 20 && (e - 20) % 18 == 0)
                    sda = (slot == nack_slot);
                else
                    sda = $urandom;
                send_item(MODE_TICK, $urandom, $urandom, $urandom, sda);
            end
            if (e < 18 && $urandom_range(0, 19) == 0)
                send_stray_start();
            for (int k = 0; k < stop_slot; k++)
            begin
                if (load_at[k] == e)
                begin
                    // Ticks while waiting for a byte do nothing
                    if (late[k])
                        repeat ($urandom_range(0, 3))
                            send_item(MODE_TICK, $urandom, $urandom, $urandom, $urandom);
                    // A second early load overwrites the first
                    if (twice[k])
                        send_item(MODE_LOAD, $urandom, $urandom, $urandom, $urandom);
                    send_item(MODE_LOAD, $urandom, $urandom, $urandom, $urandom);
                end
            end
        end
        items_sent += last_tick + 1 + stop_slot;
    endtask

    // Read transfer of n bytes; bias picks the data pattern the slave drives
    task automatic run_read(int unsigned addr, int n, bit nack_addr, int bias);
        int last_tick;
        int unsigned sda;
        last_tick = nack_addr ? 23 : 23 + 18 * n;
        send_item(MODE_READ, addr, n, $urandom, $urandom);
        for (int e = 0; e <= last_tick; e++)
        begin
            if (e > 0)
            begin
                if (e == 20)
                    sda = nack_addr;
                else if (bias == 0)
                    sda = 0;
                else if (bias == 1)
                    sda = 1;
                else
                    sda = $urandom;
                send_item(MODE_TICK, $urandom, $urandom, $urandom, sda);
            end
            // Starts on a busy bus and loads during a read are both ignored
            if ($urandom_range(0, 19) == 0)
            begin
                if (e < 18)
                    send_stray_start();
                else
                    send_item(MODE_LOAD, $urandom, $urandom, $urandom, $urandom);
            end
        end
        items_sent += last_tick + 1;
    endtask

    initial
    begin : stimulus
        int seq;
        int n;
        int nack_slot;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= MODE_TICK;
        s_axis_tdata  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick and load on an idle bus with extreme fields, then a
        // full-count write to the top address that gets no ACK on the address
        send_item(MODE_TICK, 7'h7f, 8'hff, 8'hff, 1'b1);
        send_item(MODE_LOAD, 7'h00, 8'h00, 8'h00, 1'b0);
        run_write(7'h7f, 255, 0);

        seq = 0;
        while (items_sent < 800)
        begin
            calm = (items_sent > 620);
            if (seq == 3)
                rx_hold_req = 1'b1;
            if (seq == 9)
            begin
                // Drain everything before going on
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            // Noise on an idle bus
            repeat ($urandom_range(0, 2))
                send_item($urandom_range(0, 1) ? MODE_TICK : MODE_LOAD,
                          $urandom, $urandom, $urandom, $urandom);
            // Mostly short transfers; an occasional long count ends on an address NACK
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
            if ($urandom_range(0, 1))
            begin
                if (n > 8 || $urandom_range(0, 5) == 0)
                    nack_slot = 0;
                else if (n > 0 && $urandom_range(0, 5) == 0)
                    nack_slot = $urandom_range(1, n);
                else
                    nack_slot = n + 1;
                run_write($urandom, n, nack_slot);
            end
            else
                run_read($urandom, n, n > 8 || $urandom_range(0, 5) == 0,
                         $urandom_range(0, 3));
            seq++;
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result sink: random stalls, one long hold-off on request
    initial
    begin : result_sink
        int span;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                span = 0;
                while (span < 250)
                begin
                    @(posedge clk);
                    span++;
                end
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: i2c_master_transfer_core.f
hw/rtl/i2cmt_pkg.sv
hw/rtl/i2c_master_transfer_core.sv
hw/rtl/i2cmt_checker.sv
test/i2c_transfer_checker.sv
test/testbench.sv
